// File: rtl/hcs_pkg.sv
// shared types, constants and helper functions for the hsv colour class segmenter
`timescale 1ns / 1ps
package hcs_pkg;

  localparam int unsigned NumRanges = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned DivSteps  = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_WHITE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GREEN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLACK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ORANGE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MASK   = 3'd4;

  // colour class codes
  localparam logic [2:0] CLASS_NONE   = 3'd0;
  localparam logic [2:0] CLASS_WHITE  = 3'd1;
  localparam logic [2:0] CLASS_GREEN  = 3'd2;
  localparam logic [2:0] CLASS_BLACK  = 3'd3;
  localparam logic [2:0] CLASS_ORANGE = 3'd4;

  localparam logic [7:0] HUE_FULL    = 8'd180;
  localparam logic [7:0] HUE_FOLD_AT = 8'd160;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [2:0] color_class;
    logic [7:0] paint_red;
    logic [7:0] paint_green;
    logic [7:0] paint_blue;
    logic       mask_hit;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } res_t;

  // byte 0 is hue min, byte 5 is value max
  typedef struct packed {
    logic [7:0] val_max;
    logic [7:0] val_min;
    logic [7:0] sat_max;
    logic [7:0] sat_min;
    logic [7:0] hue_max;
    logic [7:0] hue_min;
  } range_t;

  // state of both dividers as it moves down the pipe
  typedef struct packed {
    logic [15:0] sat_rem;
    logic [7:0]  sat_den;
    logic [7:0]  sat_quo;
    logic [15:0] hue_rem;
    logic [7:0]  hue_den;
    logic [7:0]  hue_quo;
    logic        hue_neg;
    sector_e     sector;
    logic        is_black;
    logic        is_grey;
    logic [7:0]  val;
  } work_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  function automatic logic in_range(range_t rg, hsv_t px);
    return (px.hue >= rg.hue_min) && (px.hue <= rg.hue_max) &&
           (px.sat >= rg.sat_min) && (px.sat <= rg.sat_max) &&
           (px.val >= rg.val_min) && (px.val <= rg.val_max);
  endfunction

  // 20 - floor(h * 0.11111) for hues 161..179
  function automatic logic [7:0] fold_hue(logic [7:0] h);
    logic [7:0] res;
    if (h >= 8'd172) begin
      res = 8'd1;
    end else if (h >= 8'd163) begin
      res = 8'd2;
    end else begin
      res = 8'd3;
    end
    return res;
  endfunction

  function automatic logic [23:0] paint_of(logic [2:0] cls);
    logic [23:0] rgb;
    case (cls)
      CLASS_NONE:   rgb = {8'd127, 8'd127, 8'd127};
      CLASS_WHITE:  rgb = {8'd255, 8'd255, 8'd255};
      CLASS_GREEN:  rgb = {8'd0, 8'd255, 8'd0};
      CLASS_BLACK:  rgb = {8'd0, 8'd0, 8'd0};
      CLASS_ORANGE: rgb = {8'd255, 8'd0, 8'd0};
      default:      rgb = {8'd127, 8'd127, 8'd127};
    endcase
    return rgb;
  endfunction

endpackage

// File: rtl/hsv_color_class_segmenter.sv
// Pixel colour segmenter: takes one RGB pixel per transfer, converts it to integer HSV and
// sorts it into white, green, black, orange or no colour (first match wins), with a paint
// colour and a separate mask hit from five 48-bit range registers that the user writes through the
// config port only while the block is idle; the block itself does not enforce this. It accepts
// one pixel every clock when the output is not stalled; the pipe holds the two 8-step restoring
// dividers (saturation and hue share each stage, one quotient bit per stage) between a min/max
// front stage and the hue finish and classify stages. Every stage has its own valid bit and
// holds while stalled, so a full pipe keeps all items.
`timescale 1ns / 1ps
module hsv_color_class_segmenter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hcs_pkg::pix_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hcs_pkg::res_t                out_data_o
);
  import hcs_pkg::*;

  // index 0 is the front stage output, index DivSteps the last divider output
  logic  div_valid [DivSteps+1];
  logic  div_ready [DivSteps+1];
  work_t div_data  [DivSteps+1];

  logic  fin_valid, fin_ready;
  hsv_t  fin_data;

  hcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_data_o  (div_data[0])
  );

  for (genvar gi = 0; gi < DivSteps; gi++) begin : g_div
    hcs_div_stage #(
      .QuoBit (DivSteps - 1 - gi)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[gi]),
      .in_ready_o  (div_ready[gi]),
      .in_data_i   (div_data[gi]),
      .out_valid_o (div_valid[gi+1]),
      .out_ready_i (div_ready[gi+1]),
      .out_data_o  (div_data[gi+1])
    );
  end

  hcs_hue_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid[DivSteps]),
    .in_ready_o  (div_ready[DivSteps]),
    .in_data_i   (div_data[DivSteps]),
    .out_valid_o (fin_valid),
    .out_ready_i (fin_ready),
    .out_data_o  (fin_data)
  );

  hcs_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (fin_valid),
    .in_ready_o  (fin_ready),
    .in_data_i   (fin_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // an open output must never hold back the input side
  a_ready_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  a_hue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hue <= HUE_FULL))
    else $error("hue above 180");

  // only a black pixel keeps hue zero
  a_hue_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.hue == 8'd0)) |-> (out_data_o.brightness == 8'd0))
    else $error("zero hue on a non-black pixel");

  a_sat_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.brightness == 8'd0)) |->
      ((out_data_o.saturation == 8'd0) && (out_data_o.hue == 8'd0)))
    else $error("black pixel with non-zero hue or saturation");

endmodule

// File: rtl/hcs_front.sv
// first stage: max, min, sector and the numerators for both divisions
`timescale 1ns / 1ps
module hcs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hcs_pkg::pix_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hcs_pkg::work_t out_data_o
);
  import hcs_pkg::*;

  logic       valid_q;
  work_t      data_q, data_d;
  logic [7:0] mx, mn, delta, mag;
  logic [8:0] diff;
  logic       neg;
  sector_e    sector;

  always_comb begin
    mx = (in_data_i.red > in_data_i.green) ? in_data_i.red : in_data_i.green;
    mn = (in_data_i.red < in_data_i.green) ? in_data_i.red : in_data_i.green;
    if (in_data_i.blue > mx) begin
      mx = in_data_i.blue;
    end
    if (in_data_i.blue < mn) begin
      mn = in_data_i.blue;
    end
    delta = mx - mn;

    if (in_data_i.red == mx) begin
      sector = SEC_RED;
      diff   = {1'b0, in_data_i.green} - {1'b0, in_data_i.blue};
    end else if (in_data_i.green == mx) begin
      sector = SEC_GREEN;
      diff   = {1'b0, in_data_i.blue} - {1'b0, in_data_i.red};
    end else begin
      sector = SEC_BLUE;
      diff   = {1'b0, in_data_i.red} - {1'b0, in_data_i.green};
    end
    neg = diff[8];
    mag = neg ? 8'(-diff) : diff[7:0];

    data_d          = '0;
    // delta*255 and mag*30 as shift and subtract
    data_d.sat_rem  = {delta, 8'd0} - {8'd0, delta};
    data_d.sat_den  = mx;
    data_d.hue_rem  = {3'd0, mag, 5'd0} - {7'd0, mag, 1'b0};
    data_d.hue_den  = delta;
    data_d.hue_neg  = neg;
    data_d.sector   = sector;
    data_d.is_black = (mx == 8'd0);
    data_d.is_grey  = (delta == 8'd0);
    data_d.val      = mx;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/hcs_div_stage.sv
// one restoring step of the saturation and hue dividers, one quotient bit each
`timescale 1ns / 1ps
module hcs_div_stage #(
  parameter int unsigned QuoBit = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hcs_pkg::work_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hcs_pkg::work_t out_data_o
);
  import hcs_pkg::*;

  logic        valid_q;
  work_t       data_q, data_d;
  logic [15:0] sat_trial, hue_trial;

  always_comb begin
    sat_trial = {8'd0, in_data_i.sat_den} << QuoBit;
    hue_trial = {8'd0, in_data_i.hue_den} << QuoBit;
    data_d    = in_data_i;
    if (in_data_i.sat_rem >= sat_trial) begin
      data_d.sat_rem         = in_data_i.sat_rem - sat_trial;
      data_d.sat_quo[QuoBit] = 1'b1;
    end
    if (in_data_i.hue_rem >= hue_trial) begin
      data_d.hue_rem         = in_data_i.hue_rem - hue_trial;
      data_d.hue_quo[QuoBit] = 1'b1;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/hcs_hue_finish.sv
// hue assembly: sector offset, sign, wrap, fold and the zero hue remap
`timescale 1ns / 1ps
module hcs_hue_finish (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hcs_pkg::work_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hcs_pkg::hsv_t  out_data_o
);
  import hcs_pkg::*;

  logic        valid_q;
  hsv_t        data_q, data_d;
  logic [7:0]  offset;
  logic [8:0]  quo_ext;
  logic signed [8:0] hh;
  logic [7:0]  h8;

  always_comb begin
    case (in_data_i.sector)
      SEC_RED:   offset = 8'd0;
      SEC_GREEN: offset = 8'd60;
      SEC_BLUE:  offset = 8'd120;
      default:   offset = 8'd0;
    endcase
    // quotient never exceeds 30 here unless the pixel is grey, where it is not used
    quo_ext = {3'd0, in_data_i.hue_quo[5:0]};
    if (in_data_i.is_grey) begin
      hh = '0;
    end else if (in_data_i.hue_neg) begin
      hh = $signed({1'b0, offset}) - $signed(quo_ext);
    end else begin
      hh = $signed({1'b0, offset}) + $signed(quo_ext);
    end
    if (hh < 0) begin
      hh = hh + $signed({1'b0, HUE_FULL});
    end
    h8 = hh[7:0];
    if (h8 > HUE_FOLD_AT) begin
      h8 = fold_hue(h8);
    end
    if (h8 == 8'd0) begin
      h8 = HUE_FULL;
    end

    data_d.val = in_data_i.val;
    if (in_data_i.is_black) begin
      data_d.hue = 8'd0;
      data_d.sat = 8'd0;
    end else begin
      data_d.hue = h8;
      data_d.sat = in_data_i.sat_quo;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/hcs_classify.sv
// range registers, priority class decision, paint colour and the output register
`timescale 1ns / 1ps
module hcs_classify (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hcs_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hcs_pkg::hsv_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hcs_pkg::res_t                  out_data_o
);
  import hcs_pkg::*;

  range_t      ranges_q [NumRanges];
  logic        valid_q;
  res_t        data_q, data_d;
  logic [2:0]  cls;
  logic [23:0] rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRanges; i++) begin
        ranges_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRanges))) begin
      ranges_q[cfg_idx_i] <= range_t'(cfg_data_i);
    end
  end

  always_comb begin
    if (in_range(ranges_q[REG_WHITE], in_data_i)) begin
      cls = CLASS_WHITE;
    end else if (in_range(ranges_q[REG_GREEN], in_data_i)) begin
      cls = CLASS_GREEN;
    end else if (in_range(ranges_q[REG_BLACK], in_data_i)) begin
      cls = CLASS_BLACK;
    end else if (in_range(ranges_q[REG_ORANGE], in_data_i)) begin
      cls = CLASS_ORANGE;
    end else begin
      cls = CLASS_NONE;
    end
    rgb = paint_of(cls);

    data_d.color_class = cls;
    data_d.paint_red   = rgb[23:16];
    data_d.paint_green = rgb[15:8];
    data_d.paint_blue  = rgb[7:0];
    data_d.mask_hit    = in_range(ranges_q[REG_MASK], in_data_i);
    data_d.hue         = in_data_i.hue;
    data_d.saturation  = in_data_i.sat;
    data_d.brightness  = in_data_i.val;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: tb/sv/hsv_color_class_segmenter_checker.sv
// checker for the colour segmenter: tracks the range windows, predicts each pixel's result
`timescale 1ns / 1ps
module hsv_color_class_segmenter_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  hcs_pkg::pix_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  hcs_pkg::res_t                out_data_i,
  output int                           mismatches_o,
  output int                           awaiting_o,
  output int                           checked_o
);
  import hcs_pkg::*;

  logic [CfgDataW-1:0] windows [NumRanges];
  res_t                expected_q [$];
  int                  mismatches;
  int                  checked;

  // bytes from the bottom: hue lo/hi, sat lo/hi, value lo/hi, all bounds inclusive
  function automatic logic window_hit(logic [CfgDataW-1:0] w, logic [7:0] h,
                                      logic [7:0] s, logic [7:0] v);
    return h >= w[7:0] && h <= w[15:8] && s >= w[23:16] && s <= w[31:24] &&
           v >= w[39:32] && v <= w[47:40];
  endfunction

  function automatic res_t classify_pixel(pix_t px);
    int   r, g, b, top, bottom, span, h;
    res_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = (r > g) ? r : g;
    bottom = (r < g) ? r : g;
    if (b > top) top = b;
    if (b < bottom) bottom = b;
    span = top - bottom;
    h = 0;
    res.brightness = 8'(top);
    res.saturation = 8'd0;
    // a black pixel keeps hue 0, no fold and no wrap to 180
    if (top != 0) begin
      res.saturation = 8'(span * 255 / top);
      if (span != 0) begin
        if (r == top) begin
          h = (g - b) * 30 / span;
        end else if (g == top) begin
          h = 60 + (b - r) * 30 / span;
        end else begin
          h = 120 + (r - g) * 30 / span;
        end
        if (h < 0) h = h + 180;
      end
      if (h > 160) h = 20 - h * 11111 / 100000;
      if (h == 0) h = 180;
    end
    res.hue = 8'(h);
    if (window_hit(windows[REG_WHITE], res.hue, res.saturation, res.brightness)) begin
      res.color_class = CLASS_WHITE;
    end else if (window_hit(windows[REG_GREEN], res.hue, res.saturation, res.brightness)) begin
      res.color_class = CLASS_GREEN;
    end else if (window_hit(windows[REG_BLACK], res.hue, res.saturation, res.brightness)) begin
      res.color_class = CLASS_BLACK;
    end else if (window_hit(windows[REG_ORANGE], res.hue, res.saturation, res.brightness)) begin
      res.color_class = CLASS_ORANGE;
    end else begin
      res.color_class = CLASS_NONE;
    end
    case (res.color_class)
      CLASS_WHITE:  {res.paint_red, res.paint_green, res.paint_blue} = 24'hFFFFFF;
      CLASS_GREEN:  {res.paint_red, res.paint_green, res.paint_blue} = 24'h00FF00;
      CLASS_BLACK:  {res.paint_red, res.paint_green, res.paint_blue} = 24'h000000;
      CLASS_ORANGE: {res.paint_red, res.paint_green, res.paint_blue} = 24'hFF0000;
      default:      {res.paint_red, res.paint_green, res.paint_blue} = 24'h7F7F7F;
    endcase
    res.mask_hit = window_hit(windows[REG_MASK], res.hue, res.saturation, res.brightness);
    return res;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("class %0d paint %02h%02h%02h mask %0d hsv %0d/%0d/%0d",
                     r.color_class, r.paint_red, r.paint_green, r.paint_blue,
                     r.mask_hit, r.hue, r.saturation, r.brightness);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    logic bad;
    if (!rst_ni) begin
      for (int k = 0; k < NumRanges; k++) windows[k] = '0;
      expected_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      // indexes past the mask register are dropped by the block
      if (cfg_we_i && cfg_idx_i < NumRanges) windows[cfg_idx_i] = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no pixel pending: %s", $realtime, show(out_data_i));
          end
        end else begin
          want = expected_q.pop_front();
          bad = out_data_i.color_class !== want.color_class ||
                out_data_i.paint_red   !== want.paint_red   ||
                out_data_i.paint_green !== want.paint_green ||
                out_data_i.paint_blue  !== want.paint_blue  ||
                out_data_i.mask_hit    !== want.mask_hit    ||
                out_data_i.hue         !== want.hue         ||
                out_data_i.saturation  !== want.saturation  ||
                out_data_i.brightness  !== want.brightness;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                       show(want), show(out_data_i));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(classify_pixel(in_data_i));
    end
    mismatches_o <= mismatches;
    awaiting_o   <= expected_q.size();
    checked_o    <= checked;
  end

endmodule

// File: tb/sv/hsv_color_class_segmenter_test.sv
// testbench top for the colour segmenter: clock, reset, pixel stimulus, window settings, verdict
`timescale 1ns / 1ps
module hsv_color_class_segmenter_test;
  import hcs_pkg::*;

  typedef enum int {
    SET_TYPICAL,
    SET_ALL_ONES,
    SET_WIDE_OPEN,
    SET_RANDOM
  } setting_e;

  localparam int SettleCycles = 16;
  localparam int RandomPhases = 8;
  localparam int PixelsPerPhase = 116;

  // corners, primaries, grey, hue fold to 1/2/3, the 160 boundary and a zero hue
  localparam logic [23:0] CornerPixels [17] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010101, 24'hFF000A, 24'hFF0064,
    24'hFF00A2, 24'hFF00AA, 24'hC83232, 24'hFE0A05, 24'h7F8001
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  pix_t                in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  res_t                out_data_o;

  int mismatch_total;
  int awaiting;
  int checked_total;
  bit idle_en = 1'b0;
  int sink_hold = 0;
  int pixels_sent = 0;
  int settings_used = 0;

  always #2 clk_i = ~clk_i;

  hsv_color_class_segmenter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  hsv_color_class_segmenter_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatch_total),
    .awaiting_o   (awaiting),
    .checked_o    (checked_total)
  );

  // result side: random stalls of the output ready while idle_en is set
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      sink_hold <= $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_pixel(input pix_t px);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  // stop sending and wait for every pending result before touching the windows
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] random_bounds();
    logic [7:0] lo, hi;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        lo = 8'd0;
        hi = 8'd255;
      end
      4, 5, 6, 7: begin
        lo = 8'($urandom_range(0, 200));
        hi = 8'($urandom_range(lo, 255));
      end
      8: begin
        // min above max, matches nothing
        lo = 8'($urandom_range(1, 255));
        hi = 8'($urandom_range(0, lo - 1));
      end
      default: begin
        lo = 8'($urandom);
        hi = lo;
      end
    endcase
    return {hi, lo};
  endfunction

  function automatic logic [CfgDataW-1:0] random_window();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return {random_bounds(), random_bounds(), random_bounds()};
    endcase
  endfunction

  task automatic load_windows(input setting_e kind);
    logic [CfgDataW-1:0] w;
    for (int k = 0; k < NumRanges; k++) begin
      case (kind)
        SET_TYPICAL: begin
          case (3'(k))
            REG_WHITE:  w = {8'd255, 8'd200, 8'd40, 8'd0, 8'd180, 8'd0};
            REG_GREEN:  w = {8'd255, 8'd40, 8'd255, 8'd80, 8'd80, 8'd40};
            REG_BLACK:  w = {8'd50, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
            REG_ORANGE: w = {8'd255, 8'd80, 8'd255, 8'd100, 8'd25, 8'd1};
            default:    w = {8'd255, 8'd30, 8'd255, 8'd50, 8'd90, 8'd30};
          endcase
        end
        SET_ALL_ONES:  w = '1;
        SET_WIDE_OPEN: w = {8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        default:       w = random_window();
      endcase
      write_window(3'(k), w);
    end
    // a write past the last register must leave every window alone
    write_window(REG_MASK + 3'($urandom_range(1, 3)), 48'({$urandom, $urandom}));
    settings_used++;
  endtask

  function automatic pix_t random_pixel();
    pix_t       px;
    logic [7:0] a, b;
    a = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 7))
      0: px = {a, a, a};
      1: px = {a, a ^ 8'($urandom_range(0, 3)), a ^ 8'($urandom_range(0, 3))};
      2: px = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
      3: px = {8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 40))};
      4: begin
        case ($urandom_range(0, 2))
          0:       px = {a, b, b};
          1:       px = {b, a, b};
          default: px = {b, b, a};
        endcase
      end
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // windows still at their reset value: only a black pixel fits
    for (int k = 0; k < 5; k++) send_pixel(CornerPixels[k]);
    settle();
    load_windows(SET_TYPICAL);
    foreach (CornerPixels[k]) send_pixel(CornerPixels[k]);
    settle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       load_windows(SET_ALL_ONES);
        1:       load_windows(SET_WIDE_OPEN);
        2:       load_windows(SET_TYPICAL);
        default: load_windows(SET_RANDOM);
      endcase
      idle_en <= (phase != 3) && (phase < RandomPhases - 2);
      for (int n = 0; n < PixelsPerPhase; n++) send_pixel(random_pixel());
      settle();
    end

    $display("covered %0d pixels over %0d window settings (reset, typical, extremes, random)",
             pixels_sent, settings_used + 1);
    $display("results checked: %0d, mismatches: %0d", checked_total, mismatch_total);
    if (mismatch_total == 0 && awaiting == 0) begin
      $display("** hsv_color_class_segmenter: PASSED **");
    end else begin
      $display("** hsv_color_class_segmenter: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", awaiting);
    $display("** hsv_color_class_segmenter: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
rtl/hcs_pkg.sv
rtl/hcs_front.sv
rtl/hcs_div_stage.sv
rtl/hcs_hue_finish.sv
rtl/hcs_classify.sv
rtl/hsv_color_class_segmenter.sv
tb/sv/hsv_color_class_segmenter_checker.sv
tb/sv/hsv_color_class_segmenter_test.sv
